[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// plain property, checked at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hw/rtl/mwid_pkg.sv]
package mwid_pkg;

  // counter width of the window and run counters
  localparam int COUNT_WIDTH = 8;
  // width of the 8-bit configuration fields
  localparam int CFG_W = 8;
  localparam int LIM_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL        = 3'd0,
    REG_SAMPLES_PER_WINDOW  = 3'd1,
    REG_MAJORITY_THRESHOLD  = 3'd2,
    REG_CONSECUTIVE_WINDOWS = 3'd3,
    REG_REPORT_ON_START     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CONF_UNKNOWN  = 2'd0,
    CONF_INACTIVE = 2'd1,
    CONF_ACTIVE   = 2'd2
  } conf_code_t;

  typedef struct packed {
    logic             active_level;
    logic [CFG_W-1:0] samples_per_window;
    logic [CFG_W-1:0] majority_threshold;
    logic [CFG_W-1:0] consecutive_windows;
    logic             report_on_start;
  } cfg_t;

  // end-of-window event from the window counter
  typedef struct packed {
    logic done;
    logic cls;
  } win_evt_t;

  typedef struct packed {
    logic report_issued;
    logic report_value;
    logic confirmed_known;
    logic confirmed_active;
  } res_t;

  // zero acts as one, values past the counter range clamp to its maximum
  function automatic logic [COUNT_WIDTH-1:0] limit_setting(input logic [CFG_W-1:0] v);
    logic [LIM_W-1:0] wide;
    wide = LIM_W'(v);
    if (v == '0) begin
      limit_setting = COUNT_WIDTH'(1);
    end else if (wide > LIM_W'(CNT_MAX)) begin
      limit_setting = CNT_MAX;
    end else begin
      limit_setting = wide[COUNT_WIDTH-1:0];
    end
  endfunction

endpackage

[hw/rtl/mwid_cfg_regs.sv]
module mwid_cfg_regs
  import mwid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level        <= 1'b1;
      cfg.samples_per_window  <= CFG_W'(8);
      cfg.majority_threshold  <= CFG_W'(5);
      cfg.consecutive_windows <= CFG_W'(2);
      cfg.report_on_start     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ACTIVE_LEVEL:        cfg.active_level        <= cfg_data[0];
        REG_SAMPLES_PER_WINDOW:  cfg.samples_per_window  <= cfg_data;
        REG_MAJORITY_THRESHOLD:  cfg.majority_threshold  <= cfg_data;
        REG_CONSECUTIVE_WINDOWS: cfg.consecutive_windows <= cfg_data;
        REG_REPORT_ON_START:     cfg.report_on_start     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/mwid_window.sv]
`include "assert_macros.svh"

module mwid_window
  import mwid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     pin_level,
  input  cfg_t     cfg,
  output win_evt_t evt
);

  logic [COUNT_WIDTH-1:0] window_sample_count;
  logic [COUNT_WIDTH-1:0] window_active_count;
  logic [COUNT_WIDTH-1:0] sample_count_next;
  logic [COUNT_WIDTH-1:0] active_count_next;
  logic [COUNT_WIDTH-1:0] win_len;

  always_comb begin
    win_len = limit_setting(cfg.samples_per_window);
    active_count_next = window_active_count;
    if (pin_level == cfg.active_level && window_active_count != CNT_MAX) begin
      active_count_next = window_active_count + COUNT_WIDTH'(1);
    end
    sample_count_next = window_sample_count;
    if (window_sample_count != CNT_MAX) begin
      sample_count_next = window_sample_count + COUNT_WIDTH'(1);
    end
    evt.done = (sample_count_next >= win_len);
    evt.cls  = (LIM_W'(active_count_next) >= LIM_W'(cfg.majority_threshold));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sample_count <= '0;
      window_active_count <= '0;
    end else if (en) begin
      if (evt.done) begin
        window_sample_count <= '0;
        window_active_count <= '0;
      end else begin
        window_sample_count <= sample_count_next;
        window_active_count <= active_count_next;
      end
    end
  end

  `ASSERT_CLK(a_active_le_samples, clk, rst, window_active_count <= window_sample_count, "active count exceeds sample count")

endmodule

[hw/rtl/mwid_confirm.sv]
`include "assert_macros.svh"

module mwid_confirm
  import mwid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  win_evt_t evt,
  input  cfg_t     cfg,
  output res_t     res
);

  logic                   have_window_class;
  logic                   last_window_class;
  logic [COUNT_WIDTH-1:0] run_length;
  conf_code_t             confirmed_code;

  logic                   have_next;
  logic                   last_next;
  logic [COUNT_WIDTH-1:0] run_next;
  conf_code_t             code_next;
  logic [COUNT_WIDTH-1:0] need;
  logic                   known;
  logic                   same_state;
  logic                   fire;

  always_comb begin
    need       = limit_setting(cfg.consecutive_windows);
    have_next  = have_window_class;
    last_next  = last_window_class;
    run_next   = run_length;
    code_next  = confirmed_code;
    known      = (confirmed_code != CONF_UNKNOWN);
    same_state = known && ((confirmed_code == CONF_ACTIVE) == evt.cls);
    fire       = 1'b0;
    res.report_issued = 1'b0;
    res.report_value  = 1'b0;

    if (evt.done) begin
      if (have_window_class && evt.cls == last_window_class) begin
        if (run_length < need) begin
          run_next = run_length + COUNT_WIDTH'(1);
        end
      end else begin
        have_next = 1'b1;
        last_next = evt.cls;
        run_next  = COUNT_WIDTH'(1);
      end
      fire = (run_next >= need) && !same_state;
      if (fire) begin
        // first confirmation from unknown reports only when enabled
        res.report_issued = known || cfg.report_on_start;
        res.report_value  = (known || cfg.report_on_start) && evt.cls;
        code_next = evt.cls ? CONF_ACTIVE : CONF_INACTIVE;
      end
    end

    res.confirmed_known  = (code_next != CONF_UNKNOWN);
    res.confirmed_active = (code_next == CONF_ACTIVE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_window_class <= 1'b0;
      last_window_class <= 1'b0;
      run_length        <= '0;
      confirmed_code    <= CONF_UNKNOWN;
    end else if (en) begin
      have_window_class <= have_next;
      last_window_class <= last_next;
      run_length        <= run_next;
      confirmed_code    <= code_next;
    end
  end

  `ASSERT_IMPL(a_no_class_no_run, clk, rst, !have_window_class, run_length == '0, "run length set without a window class")
  `ASSERT_IMPL(a_known_needs_class, clk, rst, confirmed_code != CONF_UNKNOWN, have_window_class, "state confirmed without any window class")

endmodule

[hw/rtl/majority_window_input_debouncer_top.sv]
// Majority-window pin debouncer. Each input transaction carries one pin sample; samples
// are grouped into windows of samples_per_window, a window is active when at least
// majority_threshold of its samples equal active_level, and a class is confirmed once
// consecutive_windows equal window classes follow one another. Every input transaction
// yields exactly one output transaction with the report flag/value and the confirmed
// state after that sample. Throughput is one sample per clock unless stalled. A sample
// passes an input register, then the result register; the window/run counters update in
// the same cycle as it moves into the result register. The output register lets a
// new sample enter while a finished result waits under stall. Configuration writes are
// always ready and take effect on the next cycle; write them only while no sample is in
// flight. Window size or confirm count of zero act as one; values above the counter
// range clamp to its maximum.
`include "assert_macros.svh"

module majority_window_input_debouncer_top
  import mwid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pin_level,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 report_issued,
  output logic                 report_value,
  output logic                 confirmed_known,
  output logic                 confirmed_active,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t     cfg;
  win_evt_t evt;
  res_t     res;

  // input register
  logic s1_valid;
  logic s1_pin;
  // sample moves on when the result register is empty or being drained
  logic out_free;
  logic s1_adv;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  // the input register only holds when its sample cannot move on
  assign in_stall = s1_valid && !out_free;

  mwid_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // window counting and classification
  mwid_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_adv),
    .pin_level (s1_pin),
    .cfg       (cfg),
    .evt       (evt)
  );

  // run length and state confirmation
  mwid_confirm u_confirm (
    .clk (clk),
    .rst (rst),
    .en  (s1_adv),
    .evt (evt),
    .cfg (cfg),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pin <= pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // result payload, loaded only with a new transaction
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      report_issued    <= res.report_issued;
      report_value     <= res.report_value;
      confirmed_known  <= res.confirmed_known;
      confirmed_active <= res.confirmed_active;
    end
  end

  `ASSERT_IMPL(a_report_is_state, clk, rst, out_valid && report_issued, confirmed_known && (report_value == confirmed_active), "report does not match confirmed state")
  `ASSERT_IMPL(a_no_report_no_value, clk, rst, out_valid && !report_issued, !report_value, "report value set without a report")
  `ASSERT_NEXT(a_stall_keeps_sample, clk, rst, in_stall, s1_valid, "sample lost from input register under stall")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mwid_pkg::*;

  // generous ceiling on the whole run, in clock cycles
  localparam int CYCLE_LIMIT = 250000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 pin_level;
  logic                 out_valid;
  logic                 out_stall;
  logic                 report_issued;
  logic                 report_value;
  logic                 confirmed_known;
  logic                 confirmed_active;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  majority_window_input_debouncer_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pin_level        (pin_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .report_issued    (report_issued),
    .report_value     (report_value),
    .confirmed_known  (confirmed_known),
    .confirmed_active (confirmed_active),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow copy of the configuration registers, reset values
  logic             lvl_cfg       = 1'b1;
  logic [CFG_W-1:0] win_cfg       = CFG_W'(8);
  logic [CFG_W-1:0] thr_cfg       = CFG_W'(5);
  logic [CFG_W-1:0] need_cfg      = CFG_W'(2);
  logic             start_rpt_cfg = 1'b1;

  // debouncer state as the predictor sees it
  logic [COUNT_WIDTH-1:0] smp_cnt    = '0;
  logic [COUNT_WIDTH-1:0] hit_cnt    = '0;
  logic                   cls_seen   = 1'b0;
  logic                   cls_last   = 1'b0;
  logic [COUNT_WIDTH-1:0] run_cnt    = '0;
  conf_code_t             conf_state = CONF_UNKNOWN;

  // expected status per accepted sample, oldest first
  res_t status_due[$];
  res_t due;

  int  fail_cnt     = 0;
  int  results_seen = 0;
  int  cycle_cnt    = 0;
  bit  idle_on      = 1'b1;
  bit  sending      = 1'b0;

  // clock and the single reset at the start
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // a window size or run length of zero acts as one, above counter range it saturates
  function automatic int clamp_count(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(CNT_MAX)) return int'(CNT_MAX);
    return int'(v);
  endfunction

  // advance the predicted debouncer by one pin sample and return its status
  function automatic res_t next_status(input logic pin);
    res_t r;
    int   win_len;
    int   need_len;
    logic cls;
    logic known;
    logic same;
    r        = '0;
    win_len  = clamp_count(win_cfg);
    need_len = clamp_count(need_cfg);
    if (pin == lvl_cfg && hit_cnt < CNT_MAX) hit_cnt++;
    if (smp_cnt < CNT_MAX) smp_cnt++;
    // window closes: classify it and update the run of equal classes
    if (int'(smp_cnt) >= win_len) begin
      cls     = int'(hit_cnt) >= int'(thr_cfg);
      smp_cnt = '0;
      hit_cnt = '0;
      if (cls_seen && cls == cls_last) begin
        if (int'(run_cnt) < need_len) run_cnt++;
      end else begin
        cls_seen = 1'b1;
        cls_last = cls;
        run_cnt  = COUNT_WIDTH'(1);
      end
      known = conf_state != CONF_UNKNOWN;
      same  = known && ((conf_state == CONF_ACTIVE) == cls);
      // a long enough run of a new class confirms it; the very first one is
      // reported only with report-on-start
      if (int'(run_cnt) >= need_len && !same) begin
        if (known || start_rpt_cfg) begin
          r.report_issued = 1'b1;
          r.report_value  = cls;
        end
        conf_state = cls ? CONF_ACTIVE : CONF_INACTIVE;
      end
    end
    r.confirmed_known  = conf_state != CONF_UNKNOWN;
    r.confirmed_active = conf_state == CONF_ACTIVE;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    fail_cnt++;
    if (fail_cnt <= 30) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) flag_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  // result side: every output transaction is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        flag_mismatch("result with no sample pending");
      end else begin
        due = status_due.pop_front();
        check_field("report_issued", report_issued, due.report_issued);
        check_field("report_value", report_value, due.report_value);
        check_field("confirmed_known", confirmed_known, due.confirmed_known);
        check_field("confirmed_active", confirmed_active, due.confirmed_active);
      end
      results_seen++;
    end
  end

  // receiver back-pressure in random bursts while idling is enabled
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && !rst && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // one sample transaction; valid stays high for a following sample
  task automatic send_sample(input logic pin);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    sending = 1'b1;
    do @(posedge clk); while (in_stall);
    status_due.push_back(next_status(pin));
  endtask

  // steady level with a percentage of flipped samples
  task automatic send_level(input logic lvl, input int count, input int noise_pct);
    for (int i = 0; i < count; i++) begin
      send_sample(($urandom_range(0, 99) < noise_pct) ? ~lvl : lvl);
    end
  endtask

  // mostly clean runs that can confirm a state, some noisy or pure chatter
  task automatic send_runs(input int count, input int max_run);
    int   left;
    int   len;
    int   noise;
    logic lvl;
    left = count;
    while (left > 0) begin
      lvl = 1'($urandom_range(0, 1));
      len = $urandom_range(1, max_run);
      if (len > left) len = left;
      case ($urandom_range(0, 9))
        0, 1:    noise = 50;
        2, 3, 4: noise = $urandom_range(5, 35);
        default: noise = 0;
      endcase
      send_level(lvl, len, noise);
      left -= len;
    end
  endtask

  // stop sending and wait until every expected status has come back
  task automatic wait_drained();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  // one register write transaction; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACTIVE_LEVEL:        lvl_cfg       = data[0];
      REG_SAMPLES_PER_WINDOW:  win_cfg       = data;
      REG_MAJORITY_THRESHOLD:  thr_cfg       = data;
      REG_CONSECUTIVE_WINDOWS: need_cfg      = data;
      REG_REPORT_ON_START:     start_rpt_cfg = data[0];
      default: ;
    endcase
  endtask

  // rewrite all registers once the block is idle; one-bit registers get
  // random upper bits
  task automatic load_settings(input logic al, input logic [CFG_W-1:0] win,
                               input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] need,
                               input logic ros, input bit with_unused);
    logic [CFG_W-1:0] d;
    wait_drained();
    d = CFG_W'($urandom);
    d[0] = al;
    write_reg(REG_ACTIVE_LEVEL, d);
    write_reg(REG_SAMPLES_PER_WINDOW, win);
    write_reg(REG_MAJORITY_THRESHOLD, thr);
    write_reg(REG_CONSECUTIVE_WINDOWS, need);
    d = CFG_W'($urandom);
    d[0] = ros;
    write_reg(REG_REPORT_ON_START, d);
    // indexes past the register list must be ignored
    if (with_unused) begin
      for (int k = int'(REG_REPORT_ON_START) + 1; k < (1 << CFG_IDX_W); k++) begin
        write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // reset values: confirm active from unknown, then a mixed window
  task automatic test_reset_values();
    send_level(1'b1, 16, 0);
    send_level(1'b0, 4, 0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
  endtask

  // zero and oversized settings, silent first confirmation, extremes
  task automatic test_setting_corners();
    // window of zero with run of zero: every sample confirms
    load_settings(1'b1, '0, CFG_W'(1), '0, 1'b1, 1'b1);
    send_runs(50, 6);
    // threshold zero: every window active, inverted active level
    load_settings(1'b0, CFG_W'(4), '0, CFG_W'(2), 1'b0, 1'b0);
    send_runs(40, 12);
    // threshold above the window: no window is ever active
    load_settings(1'b1, CFG_W'(3), CFG_W'(200), CFG_W'(1), 1'b1, 1'b0);
    send_runs(40, 10);
    // first confirmation is silent when report-on-start is clear
    load_settings(1'b0, CFG_W'(2), CFG_W'(1), CFG_W'(3), 1'b0, 1'b0);
    send_runs(60, 16);
    // longest run requirement with one-sample windows
    load_settings(1'b1, CFG_W'(1), CFG_W'(1), CNT_MAX, 1'b1, 1'b0);
    send_level(1'b1, 260, 0);
    send_level(1'b0, 10, 0);
    // largest window and threshold: only an all-active window counts
    load_settings(1'b0, CNT_MAX, CNT_MAX, CFG_W'(1), 1'b0, 1'b0);
    send_level(1'b1, 255, 0);
    send_level(1'b0, 255, 0);
  endtask

  // small random settings with clean runs and chatter
  task automatic test_random_settings();
    logic [CFG_W-1:0] win;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] need;
    int               span;
    for (int p = 0; p < 6; p++) begin
      win  = CFG_W'($urandom_range(0, 10));
      thr  = CFG_W'($urandom_range(0, clamp_count(win) + 2));
      need = CFG_W'($urandom_range(0, 4));
      span = clamp_count(win) * clamp_count(need) * 2 + 2;
      idle_on = (p != 2);
      load_settings(1'($urandom_range(0, 1)), win, thr, need, 1'($urandom_range(0, 1)), 1'b0);
      send_runs(25, span);
      // hold off mid-stream until the pipeline has emptied
      if (p == 3) wait_drained();
      send_runs(25, span);
    end
    idle_on = 1'b1;
  endtask

  // final stretch at full rate on both sides
  task automatic test_back_to_back();
    logic [CFG_W-1:0] win;
    logic [CFG_W-1:0] need;
    win  = CFG_W'($urandom_range(1, 6));
    need = CFG_W'($urandom_range(1, 3));
    load_settings(1'($urandom_range(0, 1)), win, CFG_W'($urandom_range(1, int'(win))), need,
                  1'b1, 1'b0);
    idle_on = 1'b0;
    send_runs(150, clamp_count(win) * clamp_count(need) * 2 + 2);
  endtask

  initial begin
    in_valid  = 1'b0;
    pin_level = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACTIVE_LEVEL;
    cfg_data  = '0;
    wait (rst == 1'b0);
    @(posedge clk);

    test_reset_values();
    test_setting_corners();
    test_random_settings();
    test_back_to_back();

    // drain, then let the two-stage pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
